// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the partition-difference rtl
// no dependencies; SYNTH removes every check from the build
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check a property on every rising edge outside reset
`define MSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("msp check failed");
// check that an antecedent implies a consequent in the same cycle
`define MSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msp check failed");
`else
`define MSP_ASSERT(lbl, prop)
`define MSP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/msp_pkg.sv =====
// shared types and constants for the minimum partition difference block
// no dependencies
package msp_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned VALUE_W     = 10;
  localparam int unsigned DIFF_W      = 10;
  localparam int unsigned MAX_SUM_DEF = 1023;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LAST,
    ST_IDLE,
    ST_PRIME,
    ST_SHIFT,
    ST_SDRAIN,
    ST_GO,
    ST_FIND,
    ST_DONE
  } msp_state_e;

  // status of the bit-serial leading-one search
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BIT_W-1:0] pos;
  } lead_stat_t;

endpackage

// ===== hw/rtl/msp_ram.sv =====
// subset-sum bitmap memory: one write port, two registered read ports
// depends on msp_pkg for the word width
module msp_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             wa_i,
  input  logic [msp_pkg::WORD_W-1:0] wd_i,
  input  logic [AW-1:0]             ra_i,
  input  logic [AW-1:0]             rb_i,
  output logic [msp_pkg::WORD_W-1:0] ra_data_o,
  output logic [msp_pkg::WORD_W-1:0] rb_data_o
);
  import msp_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] ra_q;
  logic [WORD_W-1:0] rb_q;

  // read before write on a shared address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    ra_q <= mem[ra_i];
    rb_q <= mem[rb_i];
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

// ===== hw/rtl/msp_lead.sv =====
// bit-serial leading-one search over one bitmap word, one bit a cycle
// depends on msp_pkg for the word width and the status struct
module msp_lead (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [msp_pkg::WORD_W-1:0] word_i,
  output msp_pkg::lead_stat_t        stat_o
);
  import msp_pkg::*;

  logic              busy_q;
  logic [WORD_W-1:0] sr_q;
  logic [BIT_W-1:0]  pos_q;

  // search control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && sr_q[WORD_W-1]) begin
      busy_q <= 1'b0;
    end
  end

  // shift up until the top bit is set, counting the position down
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sr_q  <= word_i;
      pos_q <= '1;
    end else if (busy_q && !sr_q[WORD_W-1]) begin
      sr_q  <= sr_q << 1;
      pos_q <= pos_q - 1'b1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && sr_q[WORD_W-1];
  assign stat_o.pos  = pos_q;

endmodule

// ===== hw/rtl/min_sum_partition_difference_top.sv =====
// Minimum partition difference of a set of integers.
// Input channel: value_i with last_item_i, taken when in_valid_i is high and
// in_stall_o is low. Output channel: min_difference_o and overflow_o, one word
// per set, taken when out_valid_o is high and out_stall_i is low.
// Each word is summed into a running total and added into a bitmap of
// reachable subset sums held in a 64-bit memory of WORDS = MAX_SUM/64 + 1 words.
// An element that fits is or-ed in by a shift-or walk through the memory, one
// word a cycle, from the top word down to the word that holds its value. A zero
// element, or any element once the total has overflowed, is taken with no walk.
// The final element adds a pass that reads and clears the bitmap, then the
// bit-serial leading-one search, skipped if the total has overflowed, before
// the result is ready for the output register.
// After reset the block runs the same clearing pass with in_stall_o high. A
// finished result sits in an output register; the block takes the next set's
// words while it waits, and holds a later result back only while that
// register is still stalled.
// depends on msp_pkg, msp_ram, msp_lead and assert_macros.svh
`include "assert_macros.svh"

module min_sum_partition_difference_top #(
  parameter int unsigned MAX_SUM = msp_pkg::MAX_SUM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [msp_pkg::VALUE_W-1:0] value_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [msp_pkg::DIFF_W-1:0]  min_difference_o,
  output logic                        overflow_o
);
  import msp_pkg::*;

  localparam int unsigned WORDS    = MAX_SUM / WORD_W + 1;
  localparam int unsigned AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned TW       = $clog2(MAX_SUM + 1);
  localparam int unsigned WS_W     = VALUE_W - BIT_W;
  localparam int unsigned IW       = ((AW > WS_W) ? AW : WS_W) + 1;
  localparam int unsigned XW       = ((AW + 7) > 11) ? (AW + 7) : 11;
  localparam int unsigned TOP_BITS = MAX_SUM % WORD_W + 1;
  localparam logic [WORD_W-1:0] TOP_MASK = (TOP_BITS == WORD_W) ? '1 :
      WORD_W'((65'd1 << TOP_BITS) - 65'd1);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [XW-1:0] MAX_X     = XW'(MAX_SUM);

  msp_state_e state_q, state_d;

  logic              last_q;
  logic              ovf_q;
  logic [TW-1:0]     total_q;
  logic [WS_W-1:0]   ws_q;
  logic [BIT_W-1:0]  bs_q;
  logic [AW-1:0]     w_q;
  logic [AW-1:0]     wd_q;
  logic              wv_q;
  logic [WORD_W-1:0] hi_q;
  logic [AW-1:0]     c_q;
  logic              sv_q;
  logic [AW-1:0]     sc_q;
  logic [AW-1:0]     bw_q;
  logic [WORD_W-1:0] bbits_q;
  logic [DIFF_W-1:0] diff_q;
  logic              out_vld_q;
  logic [DIFF_W-1:0] out_diff_q;
  logic              out_ovf_q;

  logic              in_acc;
  logic              out_free;
  logic              load_out;
  logic [XW-1:0]     sum_x;
  logic              ovf_hit;
  logic              do_add;
  logic [IW-1:0]     w_x;
  logic [IW-1:0]     wd_x;
  logic [IW-1:0]     ws_x;
  logic [IW-1:0]     lo_src_x;
  logic [IW-1:0]     hi_src_x;
  logic              w_eq_ws;
  logic              wd_eq_ws;
  logic [WORD_W-1:0] lo_eff;
  logic [2*WORD_W-1:0] cat_sh;
  logic [WORD_W-1:0] new_word;
  logic [XW-1:0]     half_x;
  logic [AW-1:0]     half_w;
  logic [BIT_W-1:0]  half_b;
  logic [WORD_W-1:0] low_mask;
  logic [WORD_W-1:0] masked;
  logic [XW-1:0]     s_x;
  logic [XW-1:0]     diff_x;

  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [WORD_W-1:0] ram_wd;
  logic [AW-1:0]     ram_ra;
  logic [AW-1:0]     ram_rb;
  logic [WORD_W-1:0] ra_data;
  logic [WORD_W-1:0] rb_data;
  lead_stat_t        lead_stat;

  // handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign load_out   = (state_q == ST_DONE) && out_free;

  // total check on an incoming word
  assign sum_x   = XW'(total_q) + XW'(value_i);
  assign ovf_hit = !ovf_q && (sum_x > MAX_X);
  assign do_add  = !ovf_q && !ovf_hit && (value_i != '0);

  // word addresses for the shift-or walk
  assign w_x      = IW'(w_q);
  assign wd_x     = IW'(wd_q);
  assign ws_x     = IW'(ws_q);
  assign lo_src_x = w_x - ws_x - IW'(1);
  assign hi_src_x = IW'(LAST_WORD) - ws_x;
  assign w_eq_ws  = (w_x == ws_x);
  assign wd_eq_ws = (wd_x == ws_x);

  // shifted source word or-ed into the destination word
  assign lo_eff   = wd_eq_ws ? '0 : ra_data;
  assign cat_sh   = {hi_q, lo_eff} << bs_q;
  always_comb begin
    new_word = rb_data | cat_sh[2*WORD_W-1:WORD_W];
    if (wd_q == LAST_WORD) begin
      new_word = new_word & TOP_MASK;
    end
  end

  // sums at most half the total, per word during the clearing pass
  assign half_x = XW'(total_q) >> 1;
  assign half_w = half_x[AW+BIT_W-1:BIT_W];
  assign half_b = half_x[BIT_W-1:0];
  always_comb begin
    if (sc_q < half_w) begin
      low_mask = '1;
    end else if (sc_q == half_w) begin
      low_mask = {WORD_W{1'b1}} >> (~half_b);
    end else begin
      low_mask = '0;
    end
  end
  assign masked = ra_data & low_mask;

  // difference from the best sum found
  assign s_x    = XW'({bw_q, lead_stat.pos});
  assign diff_x = XW'(total_q) - (s_x << 1);

  // next state and memory port control
  always_comb begin
    state_d = state_q;
    ram_we  = 1'b0;
    ram_wa  = wd_q;
    ram_wd  = new_word;
    ram_ra  = c_q;
    ram_rb  = w_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (do_add) begin
            state_d = ST_PRIME;
          end else if (last_item_i) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_PRIME: begin
        ram_ra  = hi_src_x[AW-1:0];
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        ram_ra = lo_src_x[AW-1:0];
        ram_we = wv_q;
        if (w_eq_ws) begin
          state_d = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        ram_we  = 1'b1;
        state_d = last_q ? ST_CLEAR : ST_IDLE;
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = c_q;
        ram_wd = (c_q == '0) ? WORD_W'(1) : '0;
        if (c_q == LAST_WORD) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (ovf_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_GO;
        end
      end
      ST_GO: begin
        state_d = ST_FIND;
      end
      ST_FIND: begin
        if (lead_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and set control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      last_q    <= 1'b0;
      ovf_q     <= 1'b0;
      total_q   <= '0;
      wv_q      <= 1'b0;
      c_q       <= '0;
      sv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wv_q    <= (state_q == ST_SHIFT);
      sv_q    <= (state_q == ST_CLEAR);
      c_q     <= (state_q == ST_CLEAR) ? c_q + 1'b1 : '0;
      if (in_acc) begin
        last_q <= last_item_i;
        if (ovf_hit) begin
          ovf_q <= 1'b1;
        end else if (!ovf_q) begin
          total_q <= sum_x[TW-1:0];
        end
      end else if (load_out) begin
        last_q  <= 1'b0;
        ovf_q   <= 1'b0;
        total_q <= '0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ws_q <= value_i[VALUE_W-1:BIT_W];
      bs_q <= value_i[BIT_W-1:0];
    end
    if (state_q == ST_PRIME) begin
      w_q <= LAST_WORD;
    end else if (state_q == ST_SHIFT) begin
      w_q <= w_q - 1'b1;
    end
    if (state_q == ST_SHIFT) begin
      wd_q <= w_q;
      hi_q <= ra_data;
    end
    sc_q <= c_q;
    if (sv_q && (masked != '0)) begin
      bw_q    <= sc_q;
      bbits_q <= masked;
    end
    if ((state_q == ST_FIND) && lead_stat.done) begin
      diff_q <= diff_x[DIFF_W-1:0];
    end
    if (load_out) begin
      out_diff_q <= ovf_q ? '0 : diff_q;
      out_ovf_q  <= ovf_q;
    end
  end

  msp_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wa_i      (ram_wa),
    .wd_i      (ram_wd),
    .ra_i      (ram_ra),
    .rb_i      (ram_rb),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  msp_lead u_lead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_GO),
    .word_i  (bbits_q),
    .stat_o  (lead_stat)
  );

  assign out_valid_o      = out_vld_q;
  assign min_difference_o = out_diff_q;
  assign overflow_o       = out_ovf_q;

  // checks
  `MSP_ASSERT(a_total_range, total_q <= TW'(MAX_SUM))
  `MSP_ASSERT_IMP(a_ovf_zero, out_vld_q && out_ovf_q, out_diff_q == '0)
  `MSP_ASSERT_IMP(a_pend_write, wv_q, state_q == ST_SHIFT || state_q == ST_SDRAIN)
  `MSP_ASSERT_IMP(a_find_busy, state_q == ST_FIND, lead_stat.busy)

endmodule
